// ===== hdl/apsp_pkg.sv =====
package apsp_pkg;

   // Data widths. Samples are Q1.(SAMPLE_BITS-1), coefficients Q4.20.
   localparam int SAMPLE_BITS = 24;
   localparam int STATE_BITS  = SAMPLE_BITS + 4;
   localparam int COEF_BITS   = 24;
   localparam int COEF_FRAC   = 20;
   localparam int MODE_BITS   = 3;
   localparam int CSR_INDEX_BITS = 8;
   localparam int CSR_DATA_BITS  = COEF_BITS;

   // Multiplier operand B covers the state words and the sum x +/- y1.
   localparam int OPB_BITS  = STATE_BITS + 1;
   localparam int PROD_BITS = COEF_BITS + OPB_BITS;
   localparam int ACC_BITS  = PROD_BITS - COEF_FRAC + 2;
   localparam int KX1_BITS  = COEF_BITS + STATE_BITS - COEF_FRAC + 1;

   // Filter modes.
   localparam logic [MODE_BITS-1:0] MODE_LOW_SHELF  = 3'd0;
   localparam logic [MODE_BITS-1:0] MODE_HIGH_SHELF = 3'd1;
   localparam logic [MODE_BITS-1:0] MODE_LOWPASS    = 3'd2;
   localparam logic [MODE_BITS-1:0] MODE_HIGHPASS   = 3'd3;
   localparam logic [MODE_BITS-1:0] MODE_PEAK       = 3'd4;

   // Register indexes.
   localparam logic [CSR_INDEX_BITS-1:0] REG_FILTER_MODE  = 8'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_GAIN_TERM    = 8'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_ALLPASS_COEF = 8'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_CENTRE_COEF  = 8'd3;

   // Configuration held by the register block.
   typedef struct packed {
      logic [MODE_BITS-1:0]        filter_mode;
      logic signed [COEF_BITS-1:0] gain_term;
      logic signed [COEF_BITS-1:0] allpass_coef;
      logic signed [COEF_BITS-1:0] centre_coef;
   } cfg_type;

   // Multiplier operand pairs.
   typedef enum logic [2:0] {
      MUL_C_D1,
      MUL_C_XH,
      MUL_G_XY,
      MUL_D_OMC,
      MUL_K_D1,
      MUL_C_D2
   } mul_sel_type;

   // Post-multiply operations.
   typedef enum logic [3:0] {
      ACC_NONE,
      ACC_XH_FIRST,
      ACC_Y1_FIRST,
      ACC_K,
      ACC_KX1,
      ACC_XH_PEAK,
      ACC_Y1_PEAK,
      ACC_SHELF,
      ACC_PASS,
      ACC_ZERO
   } acc_op_type;

   // Controller commands to the datapath.
   typedef struct packed {
      logic        load_x;
      logic        mul_en;
      mul_sel_type mul_sel;
      acc_op_type  acc_op;
      logic        sum_add;
      logic        load_out;
   } cmd_type;

   // Controller states.
   typedef enum logic [4:0] {
      ST_IDLE,
      ST_M_CD1,
      ST_A_XH1,
      ST_M_CXH1,
      ST_A_Y1,
      ST_M_DOMC,
      ST_A_K,
      ST_M_KD1,
      ST_A_KX1,
      ST_M_CD2,
      ST_A_XH2,
      ST_M_CXH2,
      ST_A_Y2,
      ST_M_GXY,
      ST_A_SHELF,
      ST_PASS,
      ST_ZERO,
      ST_DONE
   } state_type;

endpackage

// ===== hdl/apsp_csr.sv =====
module apsp_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [apsp_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [apsp_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   output apsp_pkg::cfg_type                   cfg
);

   apsp_pkg::cfg_type cfg_ff;
   apsp_pkg::cfg_type cfg_in;

   // Writes are always taken.
   assign csr_ready = 1'b1;

   // Decode the register index; unknown indexes are ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            apsp_pkg::REG_FILTER_MODE: begin
               cfg_in.filter_mode = csr_wdata[apsp_pkg::MODE_BITS-1:0];
            end
            apsp_pkg::REG_GAIN_TERM: begin
               cfg_in.gain_term = csr_wdata;
            end
            apsp_pkg::REG_ALLPASS_COEF: begin
               cfg_in.allpass_coef = csr_wdata;
            end
            apsp_pkg::REG_CENTRE_COEF: begin
               cfg_in.centre_coef = csr_wdata;
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.filter_mode  <= apsp_pkg::MODE_LOWPASS;
         cfg_ff.gain_term    <= '0;
         cfg_ff.allpass_coef <= '0;
         cfg_ff.centre_coef  <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hdl/apsp_ctrl.sv =====
module apsp_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic [apsp_pkg::MODE_BITS-1:0] filter_mode,
   output apsp_pkg::cmd_type              cmd
);

   apsp_pkg::state_type state_ff;
   apsp_pkg::state_type state_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic                out_free;
   logic                first_order;
   logic                is_shelf;

   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign first_order = (filter_mode == apsp_pkg::MODE_LOW_SHELF) ||
                        (filter_mode == apsp_pkg::MODE_HIGH_SHELF) ||
                        (filter_mode == apsp_pkg::MODE_LOWPASS) ||
                        (filter_mode == apsp_pkg::MODE_HIGHPASS);
   assign is_shelf    = (filter_mode == apsp_pkg::MODE_LOW_SHELF) ||
                        (filter_mode == apsp_pkg::MODE_HIGH_SHELF);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         apsp_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (first_order) begin
                  state_in = apsp_pkg::ST_M_CD1;
               end else if (filter_mode == apsp_pkg::MODE_PEAK) begin
                  state_in = apsp_pkg::ST_M_DOMC;
               end else begin
                  state_in = apsp_pkg::ST_ZERO;
               end
            end
         end
         apsp_pkg::ST_M_CD1:   state_in = apsp_pkg::ST_A_XH1;
         apsp_pkg::ST_A_XH1:   state_in = apsp_pkg::ST_M_CXH1;
         apsp_pkg::ST_M_CXH1:  state_in = apsp_pkg::ST_A_Y1;
         apsp_pkg::ST_A_Y1: begin
            state_in = is_shelf ? apsp_pkg::ST_M_GXY : apsp_pkg::ST_PASS;
         end
         apsp_pkg::ST_M_DOMC:  state_in = apsp_pkg::ST_A_K;
         apsp_pkg::ST_A_K:     state_in = apsp_pkg::ST_M_KD1;
         apsp_pkg::ST_M_KD1:   state_in = apsp_pkg::ST_A_KX1;
         apsp_pkg::ST_A_KX1:   state_in = apsp_pkg::ST_M_CD2;
         apsp_pkg::ST_M_CD2:   state_in = apsp_pkg::ST_A_XH2;
         apsp_pkg::ST_A_XH2:   state_in = apsp_pkg::ST_M_CXH2;
         apsp_pkg::ST_M_CXH2:  state_in = apsp_pkg::ST_A_Y2;
         apsp_pkg::ST_A_Y2:    state_in = apsp_pkg::ST_M_GXY;
         apsp_pkg::ST_M_GXY:   state_in = apsp_pkg::ST_A_SHELF;
         apsp_pkg::ST_A_SHELF: state_in = apsp_pkg::ST_DONE;
         apsp_pkg::ST_PASS:    state_in = apsp_pkg::ST_DONE;
         apsp_pkg::ST_ZERO:    state_in = apsp_pkg::ST_DONE;
         apsp_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = apsp_pkg::ST_IDLE;
            end
         end
         default: state_in = apsp_pkg::ST_IDLE;
      endcase
   end

   // Commands to the datapath.
   always_comb begin
      cmd          = '0;
      cmd.mul_sel  = apsp_pkg::MUL_C_D1;
      cmd.acc_op   = apsp_pkg::ACC_NONE;
      cmd.sum_add  = (filter_mode == apsp_pkg::MODE_LOW_SHELF) ||
                     (filter_mode == apsp_pkg::MODE_LOWPASS);
      req_ready    = 1'b0;
      case (state_ff)
         apsp_pkg::ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.load_x = req_valid;
         end
         apsp_pkg::ST_M_CD1: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = apsp_pkg::MUL_C_D1;
         end
         apsp_pkg::ST_A_XH1:   cmd.acc_op = apsp_pkg::ACC_XH_FIRST;
         apsp_pkg::ST_M_CXH1: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = apsp_pkg::MUL_C_XH;
         end
         apsp_pkg::ST_A_Y1:    cmd.acc_op = apsp_pkg::ACC_Y1_FIRST;
         apsp_pkg::ST_M_DOMC: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = apsp_pkg::MUL_D_OMC;
         end
         apsp_pkg::ST_A_K:     cmd.acc_op = apsp_pkg::ACC_K;
         apsp_pkg::ST_M_KD1: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = apsp_pkg::MUL_K_D1;
         end
         apsp_pkg::ST_A_KX1:   cmd.acc_op = apsp_pkg::ACC_KX1;
         apsp_pkg::ST_M_CD2: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = apsp_pkg::MUL_C_D2;
         end
         apsp_pkg::ST_A_XH2:   cmd.acc_op = apsp_pkg::ACC_XH_PEAK;
         apsp_pkg::ST_M_CXH2: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = apsp_pkg::MUL_C_XH;
         end
         apsp_pkg::ST_A_Y2:    cmd.acc_op = apsp_pkg::ACC_Y1_PEAK;
         apsp_pkg::ST_M_GXY: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = apsp_pkg::MUL_G_XY;
         end
         apsp_pkg::ST_A_SHELF: cmd.acc_op = apsp_pkg::ACC_SHELF;
         apsp_pkg::ST_PASS:    cmd.acc_op = apsp_pkg::ACC_PASS;
         apsp_pkg::ST_ZERO:    cmd.acc_op = apsp_pkg::ACC_ZERO;
         apsp_pkg::ST_DONE:    cmd.load_out = out_free;
         default:              req_ready = 1'b0;
      endcase
   end

   // Result valid flag: set when the output register loads, cleared on transaction.
   assign rsp_valid_in = cmd.load_out || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= apsp_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== hdl/apsp_datapath.sv =====
module apsp_datapath (
   input  logic                                    clock,
   input  logic                                    reset,
   input  apsp_pkg::cfg_type                       cfg,
   input  apsp_pkg::cmd_type                       cmd,
   input  logic signed [apsp_pkg::SAMPLE_BITS-1:0] req_sample_in,
   output logic signed [apsp_pkg::SAMPLE_BITS-1:0] rsp_sample_out
);

   localparam int SB  = apsp_pkg::SAMPLE_BITS;
   localparam int STB = apsp_pkg::STATE_BITS;
   localparam int CB  = apsp_pkg::COEF_BITS;
   localparam int CF  = apsp_pkg::COEF_FRAC;
   localparam int OB  = apsp_pkg::OPB_BITS;
   localparam int PB  = apsp_pkg::PROD_BITS;
   localparam int AB  = apsp_pkg::ACC_BITS;
   localparam int KB  = apsp_pkg::KX1_BITS;

   localparam logic signed [AB-1:0] STATE_MAX  = AB'((64'sd1 <<< (STB - 1)) - 64'sd1);
   localparam logic signed [AB-1:0] STATE_MIN  = -STATE_MAX - AB'(1);
   localparam logic signed [AB-1:0] SAMPLE_MAX = AB'((64'sd1 <<< (SB - 1)) - 64'sd1);
   localparam logic signed [AB-1:0] SAMPLE_MIN = -SAMPLE_MAX - AB'(1);
   localparam logic signed [AB-1:0] COEF_MAX   = AB'((64'sd1 <<< (CB - 1)) - 64'sd1);
   localparam logic signed [AB-1:0] COEF_MIN   = -COEF_MAX - AB'(1);
   localparam logic signed [CB:0]   ONE_COEF   = (CB + 1)'(64'sd1 <<< CF);
   localparam logic signed [PB:0]   HALF_20    = (PB + 1)'(64'sd1 <<< (CF - 1));
   localparam logic signed [PB:0]   HALF_21    = (PB + 1)'(64'sd1 <<< CF);

   function automatic logic signed [STB-1:0] sat_state(input logic signed [AB-1:0] v);
      logic signed [AB-1:0] r;
      r = (v > STATE_MAX) ? STATE_MAX : ((v < STATE_MIN) ? STATE_MIN : v);
      return r[STB-1:0];
   endfunction

   function automatic logic signed [SB-1:0] sat_sample(input logic signed [AB-1:0] v);
      logic signed [AB-1:0] r;
      r = (v > SAMPLE_MAX) ? SAMPLE_MAX : ((v < SAMPLE_MIN) ? SAMPLE_MIN : v);
      return r[SB-1:0];
   endfunction

   function automatic logic signed [CB-1:0] sat_coef(input logic signed [AB-1:0] v);
      logic signed [AB-1:0] r;
      r = (v > COEF_MAX) ? COEF_MAX : ((v < COEF_MIN) ? COEF_MIN : v);
      return r[CB-1:0];
   endfunction

   logic signed [SB-1:0]  x_ff,   x_in;
   logic signed [PB-1:0]  prod_ff, prod_in;
   logic signed [STB-1:0] d1_ff,  d1_in;
   logic signed [STB-1:0] d2_ff,  d2_in;
   logic signed [STB-1:0] xh_ff,  xh_in;
   logic signed [STB-1:0] y1_ff,  y1_in;
   logic signed [CB-1:0]  k_ff,   k_in;
   logic signed [KB-1:0]  kx1_ff, kx1_in;
   logic signed [SB-1:0]  y_ff,   y_in;
   logic signed [SB-1:0]  out_ff, out_in;

   logic signed [CB:0]    omc;
   logic signed [OB-1:0]  xy;
   logic signed [CB-1:0]  opa;
   logic signed [OB-1:0]  opb;
   logic signed [PB:0]    rnd20_full;
   logic signed [PB:0]    rnd21_full;
   logic signed [AB-1:0]  r20;
   logic signed [AB-1:0]  r21;
   logic signed [OB-1:0]  xy_half;
   logic signed [AB-1:0]  x_acc;
   logic signed [AB-1:0]  kx1_acc;
   logic signed [AB-1:0]  d1_acc;
   logic signed [AB-1:0]  d2_acc;

   // Shared operands.
   assign omc = ONE_COEF - (CB + 1)'(cfg.allpass_coef);
   assign xy  = cmd.sum_add ? (OB'(x_ff) + OB'(y1_ff)) : (OB'(x_ff) - OB'(y1_ff));

   // Operand selection for the single multiplier.
   always_comb begin
      case (cmd.mul_sel)
         apsp_pkg::MUL_C_D1: begin
            opa = cfg.allpass_coef;
            opb = OB'(d1_ff);
         end
         apsp_pkg::MUL_C_XH: begin
            opa = cfg.allpass_coef;
            opb = OB'(xh_ff);
         end
         apsp_pkg::MUL_G_XY: begin
            opa = cfg.gain_term;
            opb = xy;
         end
         apsp_pkg::MUL_D_OMC: begin
            opa = cfg.centre_coef;
            opb = OB'(omc);
         end
         apsp_pkg::MUL_K_D1: begin
            opa = k_ff;
            opb = OB'(d1_ff);
         end
         apsp_pkg::MUL_C_D2: begin
            opa = cfg.allpass_coef;
            opb = OB'(d2_ff);
         end
         default: begin
            opa = cfg.allpass_coef;
            opb = OB'(d1_ff);
         end
      endcase
   end

   // Round half up of the registered product by 20 and 21 fraction bits.
   assign rnd20_full = ((PB + 1)'(prod_ff) + HALF_20) >>> CF;
   assign rnd21_full = ((PB + 1)'(prod_ff) + HALF_21) >>> (CF + 1);
   assign r20        = AB'(rnd20_full);
   assign r21        = AB'(rnd21_full);
   assign xy_half    = (xy + OB'(1)) >>> 1;
   assign x_acc      = AB'(x_ff);
   assign kx1_acc    = AB'(kx1_ff);
   assign d1_acc     = AB'(d1_ff);
   assign d2_acc     = AB'(d2_ff);

   // Register next values.
   always_comb begin
      x_in    = cmd.load_x ? req_sample_in : x_ff;
      prod_in = cmd.mul_en ? (PB'(opa) * PB'(opb)) : prod_ff;
      d1_in   = d1_ff;
      d2_in   = d2_ff;
      xh_in   = xh_ff;
      y1_in   = y1_ff;
      k_in    = k_ff;
      kx1_in  = kx1_ff;
      y_in    = y_ff;
      out_in  = cmd.load_out ? y_ff : out_ff;
      case (cmd.acc_op)
         apsp_pkg::ACC_XH_FIRST: begin
            xh_in = sat_state(x_acc - r20);
         end
         apsp_pkg::ACC_Y1_FIRST: begin
            y1_in = sat_state(r20 + d1_acc);
            d1_in = xh_ff;
         end
         apsp_pkg::ACC_K: begin
            k_in = sat_coef(r20);
         end
         apsp_pkg::ACC_KX1: begin
            kx1_in = KB'(r20);
         end
         apsp_pkg::ACC_XH_PEAK: begin
            xh_in = sat_state(x_acc - kx1_acc + r20);
         end
         apsp_pkg::ACC_Y1_PEAK: begin
            // The second delay takes the old first delay.
            y1_in = sat_state(kx1_acc + d2_acc - r20);
            d2_in = d1_ff;
            d1_in = xh_ff;
         end
         apsp_pkg::ACC_SHELF: begin
            y_in = sat_sample(r21 + x_acc);
         end
         apsp_pkg::ACC_PASS: begin
            y_in = sat_sample(AB'(xy_half));
         end
         apsp_pkg::ACC_ZERO: begin
            y_in = '0;
         end
         default: begin
            y_in = y_ff;
         end
      endcase
   end

   // Allpass state words are cleared at reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         d1_ff <= '0;
         d2_ff <= '0;
      end else begin
         d1_ff <= d1_in;
         d2_ff <= d2_in;
      end
   end

   // Working and output registers.
   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      prod_ff <= prod_in;
      xh_ff  <= xh_in;
      y1_ff  <= y1_in;
      k_ff   <= k_in;
      kx1_ff <= kx1_in;
      y_ff   <= y_in;
      out_ff <= out_in;
   end

   assign rsp_sample_out = out_ff;

endmodule

// ===== hdl/allpass_shelving_peak_filter.sv =====
// Lowpass and highpass run the first-order allpass and a pass step; the shelves replace
// the pass step with a gain multiply; peak runs the second-order allpass and the gain
// multiply; an undefined mode gives zero. One item at a time; the next item is taken
// in the cycle after the result is loaded. One shared 24 x 29 multiplier is used.
// Reset is synchronous: it clears both allpass delays, the controller and the result
// valid flag, and loads the registers with lowpass mode and zero coefficients.
module allpass_shelving_peak_filter (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic signed [apsp_pkg::SAMPLE_BITS-1:0] req_sample_in,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [apsp_pkg::SAMPLE_BITS-1:0] rsp_sample_out,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [apsp_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [apsp_pkg::CSR_DATA_BITS-1:0]      csr_wdata
);

   apsp_pkg::cfg_type cfg;
   apsp_pkg::cmd_type cmd;

   // Configuration registers.
   apsp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Sequencer.
   apsp_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .filter_mode (cfg.filter_mode),
      .cmd         (cmd)
   );

   // Arithmetic and state.
   apsp_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .cmd            (cmd),
      .req_sample_in  (req_sample_in),
      .rsp_sample_out (rsp_sample_out)
   );

endmodule

// ===== hdl/apsp_checker.sv =====
module apsp_checker (
   input logic                                    clock,
   input logic                                    reset,
   input logic                                    req_valid,
   input logic                                    req_ready,
   input logic                                    rsp_valid,
   input logic                                    rsp_ready,
   input logic signed [apsp_pkg::SAMPLE_BITS-1:0] rsp_sample_out
);

   // A result waiting for the consumer holds its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample_out))
      else $error("result changed or dropped while stalled");

   // An input transaction is followed by a busy period with req_ready low.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready ##1 !req_ready)
      else $error("input accepted while an item is in progress");

   // A new result only appears at the end of a busy period.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared without an item in progress");

   // Reset leaves no result pending.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind allpass_shelving_peak_filter apsp_checker u_apsp_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_sample_out (rsp_sample_out)
);

// ===== test/tb_top.sv =====
module tb_top;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SB              = apsp_pkg::SAMPLE_BITS;
   localparam int CYCLE_LIMIT     = 600000;
   localparam int IDLE_SETTLE     = 16;
   localparam int END_SETTLE      = 30;
   localparam int MAX_SEND_GAP    = 15;
   localparam int MISMATCH_PRINTS = 40;
   localparam int MODE_CODES      = 1 << apsp_pkg::MODE_BITS;
   localparam int SETTINGS_PER_PHASE = 6;
   localparam int ITEMS_PER_SETTING  = 75;

   localparam logic [apsp_pkg::CSR_INDEX_BITS-1:0] REG_FIRST_UNUSED =
      apsp_pkg::CSR_INDEX_BITS'(apsp_pkg::REG_CENTRE_COEF + 1);
   localparam logic [apsp_pkg::CSR_INDEX_BITS-1:0] REG_INDEX_TOP    = '1;

   localparam logic [apsp_pkg::COEF_BITS-1:0] COEF_MAX =
      {1'b0, {(apsp_pkg::COEF_BITS-1){1'b1}}};
   localparam logic [apsp_pkg::COEF_BITS-1:0] COEF_MIN =
      {1'b1, {(apsp_pkg::COEF_BITS-1){1'b0}}};
   localparam logic signed [SB-1:0] SAMPLE_MAX = {1'b0, {(SB-1){1'b1}}};
   localparam logic signed [SB-1:0] SAMPLE_MIN = {1'b1, {(SB-1){1'b0}}};
   localparam int UNITY = 1 << apsp_pkg::COEF_FRAC;

   // Block ports; the inputs are at known values from time zero.
   logic                                    clock = 1'b0;
   logic                                    reset = 1'b1;
   logic                                    req_valid = 1'b0;
   logic                                    req_ready;
   logic signed [SB-1:0]                    req_sample_in = '0;
   logic                                    rsp_valid;
   logic                                    rsp_ready = 1'b0;
   logic signed [SB-1:0]                    rsp_sample_out;
   logic                                    csr_valid = 1'b0;
   logic                                    csr_ready;
   logic [apsp_pkg::CSR_INDEX_BITS-1:0]     csr_index = '0;
   logic [apsp_pkg::CSR_DATA_BITS-1:0]      csr_wdata = '0;

   // Mirror of the filter configuration and its two allpass delay words.
   logic [apsp_pkg::MODE_BITS-1:0] mode_now = apsp_pkg::MODE_LOWPASS;
   longint               gain_now = 0;
   longint               apc_now = 0;
   longint               centre_now = 0;
   longint               hist_xh1 = 0;
   longint               hist_xh2 = 0;

   logic signed [SB-1:0] expected_samples[$];
   int                   mismatch_count = 0;
   int                   result_count = 0;
   int                   cycle_count = 0;
   int                   send_idle_pct = 0;
   int                   recv_idle_pct = 0;

   allpass_shelving_peak_filter dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sample_out (rsp_sample_out),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always #2 clock = ~clock;

   // Saturate a value to a signed word of the given width.
   function automatic longint clamp(input longint v, input int bits);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (bits - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   // Drop s fraction bits, rounding half up.
   function automatic longint round_drop(input longint v, input int s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
   endfunction

   function automatic longint coef_mul(input longint coef, input longint v);
      return round_drop(coef * v, apsp_pkg::COEF_FRAC);
   endfunction

   // Filtered sample for one input, advancing the mirrored allpass delays.
   function automatic logic signed [SB-1:0] filter_next(input logic signed [SB-1:0] smp);
      longint x;
      longint y;
      longint xh;
      longint y1;
      longint k;
      longint kx1;
      x = smp;
      y = 0;
      if (mode_now <= apsp_pkg::MODE_HIGHPASS) begin
         xh = clamp(x - coef_mul(apc_now, hist_xh1), apsp_pkg::STATE_BITS);
         y1 = clamp(coef_mul(apc_now, xh) + hist_xh1, apsp_pkg::STATE_BITS);
         case (mode_now)
            apsp_pkg::MODE_LOW_SHELF:
               y = round_drop(gain_now * (x + y1), apsp_pkg::COEF_FRAC + 1) + x;
            apsp_pkg::MODE_HIGH_SHELF:
               y = round_drop(gain_now * (x - y1), apsp_pkg::COEF_FRAC + 1) + x;
            apsp_pkg::MODE_LOWPASS: y = round_drop(x + y1, 1);
            default: y = round_drop(x - y1, 1);
         endcase
         hist_xh1 = xh;
      end else if (mode_now == apsp_pkg::MODE_PEAK) begin
         k = clamp(coef_mul(centre_now, longint'(UNITY) - apc_now), apsp_pkg::COEF_BITS);
         kx1 = coef_mul(k, hist_xh1);
         xh = clamp(x - kx1 + coef_mul(apc_now, hist_xh2), apsp_pkg::STATE_BITS);
         y1 = clamp(-coef_mul(apc_now, xh) + kx1 + hist_xh2, apsp_pkg::STATE_BITS);
         y = round_drop(gain_now * (x - y1), apsp_pkg::COEF_FRAC + 1) + x;
         hist_xh2 = hist_xh1;
         hist_xh1 = xh;
      end
      return SB'(clamp(y, SB));
   endfunction

   task automatic report_mismatch(input string msg);
      if (mismatch_count < MISMATCH_PRINTS) $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
      mismatch_count++;
   endtask

   // Cycle counter and run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("allpass_shelving_peak_filter verification failed");
         $finish;
      end
   end

   // Result receiver with random back-pressure.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Compare each result transaction with the oldest predicted sample.
   always @(posedge clock) begin : check_results
      logic signed [SB-1:0] want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_samples.size() == 0) begin
            report_mismatch($sformatf("result %0d with nothing pending", rsp_sample_out));
         end else begin
            want = expected_samples.pop_front();
            if (rsp_sample_out !== want)
               report_mismatch($sformatf("result #%0d sample_out %0d, predicted %0d",
                                         result_count, rsp_sample_out, want));
         end
         result_count++;
      end
   end

   // Send one sample transaction after a random gap and predict its result.
   task automatic send_sample(input logic signed [SB-1:0] smp);
      int gap;
      gap = 0;
      while (gap < MAX_SEND_GAP && $urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_sample_in <= smp;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_samples.push_back(filter_next(smp));
   endtask

   // Hold the sender until every pending result has arrived and the block is quiet.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_samples.size() != 0) @(posedge clock);
      repeat (IDLE_SETTLE) @(posedge clock);
   endtask

   // One register write transaction; the mirror follows the register decode.
   task automatic csr_write(input logic [apsp_pkg::CSR_INDEX_BITS-1:0] idx,
                            input logic [apsp_pkg::CSR_DATA_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         apsp_pkg::REG_FILTER_MODE: mode_now = data[apsp_pkg::MODE_BITS-1:0];
         apsp_pkg::REG_GAIN_TERM: gain_now = longint'($signed(data));
         apsp_pkg::REG_ALLPASS_COEF: apc_now = longint'($signed(data));
         apsp_pkg::REG_CENTRE_COEF: centre_now = longint'($signed(data));
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_setting(input logic [apsp_pkg::CSR_DATA_BITS-1:0] mode_word,
                                input logic [apsp_pkg::COEF_BITS-1:0] gain,
                                input logic [apsp_pkg::COEF_BITS-1:0] apc,
                                input logic [apsp_pkg::COEF_BITS-1:0] centre);
      wait_idle();
      csr_write(apsp_pkg::REG_FILTER_MODE, mode_word);
      csr_write(apsp_pkg::REG_GAIN_TERM, gain);
      csr_write(apsp_pkg::REG_ALLPASS_COEF, apc);
      csr_write(apsp_pkg::REG_CENTRE_COEF, centre);
   endtask

   // Coefficient: mostly inside a useful range, sometimes an extreme or any word.
   function automatic logic [apsp_pkg::COEF_BITS-1:0] pick_coef(input int lo, input int hi);
      int r;
      r = $urandom_range(9);
      if (r == 0) return COEF_MAX;
      if (r == 1) return COEF_MIN;
      if (r == 2) return apsp_pkg::COEF_BITS'($urandom());
      return apsp_pkg::COEF_BITS'(lo + int'($urandom_range(hi - lo)));
   endfunction

   function automatic logic signed [SB-1:0] pick_sample();
      int r;
      r = $urandom_range(7);
      if (r == 0) return ($urandom_range(1) != 0) ? SAMPLE_MAX : SAMPLE_MIN;
      if (r <= 2) return SB'($signed($urandom_range(1 << 17)) - (1 << 16));
      return SB'($urandom());
   endfunction

   // Reset configuration: lowpass with a zero allpass coefficient.
   task automatic test_reset_state();
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      send_sample('0);
   endtask

   // Every mode code, defined or not, with extreme coefficients that saturate
   // the peak factor, the allpass words and the output.
   task automatic test_each_mode();
      for (int m = 0; m < MODE_CODES; m++) begin
         if (m % 2 == 0)
            apply_setting(apsp_pkg::CSR_DATA_BITS'(m), COEF_MAX, COEF_MIN, COEF_MAX);
         else
            apply_setting(apsp_pkg::CSR_DATA_BITS'(m), COEF_MIN, COEF_MAX, COEF_MIN);
         send_sample(SAMPLE_MAX);
         if (m <= int'(apsp_pkg::MODE_PEAK)) send_sample(SAMPLE_MIN);
      end
   endtask

   // Writes beyond the register list change nothing, and the mode register
   // keeps only its low bits.
   task automatic test_register_decode();
      apply_setting(apsp_pkg::CSR_DATA_BITS'(apsp_pkg::MODE_HIGH_SHELF),
                    apsp_pkg::CSR_DATA_BITS'(UNITY / 2),
                    apsp_pkg::CSR_DATA_BITS'(UNITY / 4),
                    apsp_pkg::CSR_DATA_BITS'(-UNITY / 2));
      csr_write(REG_FIRST_UNUSED, '1);
      csr_write(REG_INDEX_TOP, '1);
      send_sample(-SB'(12345));
      wait_idle();
      csr_write(apsp_pkg::REG_FILTER_MODE,
                {{(apsp_pkg::CSR_DATA_BITS-apsp_pkg::MODE_BITS){1'b1}}, apsp_pkg::MODE_PEAK});
      send_sample(SB'(700000));
   endtask

   // Random settings, each followed by a run of random samples. Every setting
   // change waits for all pending results first.
   task automatic test_random_traffic(input int send_pct, input int recv_pct);
      logic [apsp_pkg::CSR_DATA_BITS-1:0] mode_word;
      logic [apsp_pkg::MODE_BITS-1:0]     mode_code;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      for (int s = 0; s < SETTINGS_PER_PHASE; s++) begin
         if ($urandom_range(7) == 0)
            mode_code = apsp_pkg::MODE_BITS'($urandom_range(MODE_CODES - 1));
         else
            mode_code = apsp_pkg::MODE_BITS'($urandom_range(int'(apsp_pkg::MODE_PEAK)));
         mode_word = {(apsp_pkg::CSR_DATA_BITS-apsp_pkg::MODE_BITS)'($urandom()), mode_code};
         if ($urandom_range(3) != 0)
            mode_word[apsp_pkg::CSR_DATA_BITS-1:apsp_pkg::MODE_BITS] = '0;
         apply_setting(mode_word, pick_coef(-UNITY, 3 * UNITY),
                       pick_coef(-UNITY + 1, UNITY - 1), pick_coef(-UNITY, UNITY));
         if ($urandom_range(3) == 0)
            csr_write(apsp_pkg::CSR_INDEX_BITS'($urandom_range(int'(REG_INDEX_TOP),
                                                              int'(REG_FIRST_UNUSED))),
                      apsp_pkg::CSR_DATA_BITS'($urandom()));
         for (int i = 0; i < ITEMS_PER_SETTING; i++) begin
            send_sample(pick_sample());
            // Occasionally hold off until the block has drained.
            if ($urandom_range(63) == 0) wait_idle();
         end
      end
   endtask

   initial begin
      send_idle_pct = 33;
      recv_idle_pct = 78;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_state();
      test_each_mode();
      test_register_decode();
      test_random_traffic(33, 78);
      test_random_traffic(78, 33);
      test_random_traffic(0, 0);

      // Drain, then allow the longest latency for any stray result.
      wait_idle();
      repeat (END_SETTLE) @(posedge clock);
      if (mismatch_count == 0 && expected_samples.size() == 0) begin
         $display("allpass_shelving_peak_filter verification clean");
      end else begin
         $display("allpass_shelving_peak_filter verification failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/apsp_pkg.sv
hdl/apsp_csr.sv
hdl/apsp_ctrl.sv
hdl/apsp_datapath.sv
hdl/allpass_shelving_peak_filter.sv
hdl/apsp_checker.sv
test/tb_top.sv
